// File: src/sliding_window_aggregator_core_defines.svh
`ifndef SLIDING_WINDOW_AGGREGATOR_CORE_DEFINES_SVH
`define SLIDING_WINDOW_AGGREGATOR_CORE_DEFINES_SVH

// Holds at every edge once reset is released.
`define SWA_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SWA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/swa_pkg.sv
package swa_pkg;

  typedef enum logic [1:0] {
    KIND_MIN = 2'd0,
    KIND_MAX = 2'd1,
    KIND_CNT = 2'd2,
    KIND_SUM = 2'd3
  } agg_kind_t;

  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_SLIDE = 2'd2;

  localparam int CfgWidth = 11;
  localparam logic [CfgWidth-1:0] SIZE_RESET  = 11'd16;
  localparam logic [CfgWidth-1:0] SLIDE_RESET = 11'd4;

  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RB_RD,
    ST_RB_WR,
    ST_UPD,
    ST_RES
  } swa_state_t;

  function automatic logic [31:0] agg_identity(agg_kind_t k);
    case (k)
      KIND_MIN: agg_identity = INT_MAX;
      KIND_MAX: agg_identity = INT_MIN;
      default:  agg_identity = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] agg_lift(agg_kind_t k, logic [31:0] s);
    agg_lift = (k == KIND_CNT) ? 32'd1 : s;
  endfunction

  function automatic logic [31:0] agg_combine(agg_kind_t k, logic [31:0] a, logic [31:0] b);
    case (k)
      KIND_MIN: agg_combine = ($signed(a) < $signed(b)) ? a : b;
      KIND_MAX: agg_combine = ($signed(a) > $signed(b)) ? a : b;
      default:  agg_combine = a + b;
    endcase
  endfunction

endpackage

// File: src/swa_sample_if.sv
interface swa_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: src/swa_result_if.sv
interface swa_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_value;
  logic               window_full;

  modport source (output valid, output window_value, output window_full, input ready);
  modport sink (input valid, input window_value, input window_full, output ready);
endinterface

// File: src/swa_cfg_if.sv
interface swa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/sliding_window_aggregator_core.sv
// Channel  Direction  Payload
// cfg      sink       index (2b), data (11b)
// feed     sink       sample (32b signed)
// result   source     window_value (32b signed), window_full
//
// A sample is accepted, then applied in the update step; when it closes a
// slide, a result step follows with the suffix stack top read from memory.
// When an old sample must leave and the back stack is empty, a rebuild first
// walks the front entries in the ring (ring read, stack write per entry).
// Synchronous reset clears control; both memories are not cleared.
// A new result waits in the result step while the last one is still held;
// feed and cfg stall until it is taken.
module sliding_window_aggregator_core #(
  parameter int MAX_WINDOW = 1024
) (
  input logic        clk,
  input logic        rst,
  swa_cfg_if.sink    cfg,
  swa_sample_if.sink feed,
  swa_result_if.source result
);
  import swa_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);

  agg_kind_t           kind;
  logic [CfgWidth-1:0] size_cfg;
  logic [CfgWidth-1:0] slide_cfg;

  swa_state_t state, state_next;

  logic [31:0]   value_ring [MAX_WINDOW];
  logic [31:0]   suffix_stack [MAX_WINDOW];
  logic [31:0]   ring_q;
  logic [31:0]   stack_q;

  logic [31:0]   sample_hold;
  logic [31:0]   front_aggregate;
  logic [CW-1:0] front_count;
  logic [CW-1:0] back_count;
  logic [AW-1:0] ring_write_index;
  logic [CW-1:0] items_held;
  logic [CfgWidth-1:0] slide_progress;

  logic [CW-1:0] rb_k;
  logic [AW-1:0] rb_idx;
  logic [31:0]   rb_acc;

  logic [CW-1:0] eff_size;
  logic [CfgWidth-1:0] eff_slide;
  logic          full_now;
  logic          evict;
  logic          emit;
  logic [CW-1:0] back_count_next;
  logic [AW-1:0] rb_idx_next;
  logic [31:0]   rb_acc_next;
  logic [31:0]   back_top;
  logic          cfg_we;
  logic          feed_acc;
  logic          res_load;

  always_comb begin
    if (size_cfg == '0) begin
      eff_size = CW'(1);
    end else if (32'(size_cfg) > 32'(MAX_WINDOW)) begin
      eff_size = CW'(MAX_WINDOW);
    end else begin
      eff_size = CW'(size_cfg);
    end
    eff_slide = (slide_cfg == '0) ? CfgWidth'(1) : slide_cfg;
  end

  assign full_now = items_held >= eff_size;
  assign evict    = full_now && (back_count != '0);
  assign back_count_next = evict ? back_count - CW'(1) : back_count;
  assign emit = ({1'b0, slide_progress} + (CfgWidth+1)'(1)) >= {1'b0, eff_slide};
  assign rb_idx_next = (rb_idx == '0) ? AW'(MAX_WINDOW - 1) : rb_idx - AW'(1);
  assign rb_acc_next = agg_combine(kind, agg_lift(kind, ring_q), rb_acc);
  assign back_top = (back_count != '0) ? stack_q : agg_identity(kind);

  assign cfg.ready   = (state == ST_IDLE);
  assign cfg_we      = cfg.valid && cfg.ready;
  assign feed.ready  = (state == ST_IDLE);
  assign feed_acc    = feed.valid && feed.ready;
  assign res_load    = (state == ST_RES) && (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (feed_acc) begin
          state_next = (full_now && back_count == '0) ? ST_RB_RD : ST_UPD;
        end
      end
      ST_RB_RD: state_next = ST_RB_WR;
      ST_RB_WR: state_next = (rb_k + CW'(1) == front_count) ? ST_UPD : ST_RB_RD;
      ST_UPD:   state_next = emit ? ST_RES : ST_IDLE;
      ST_RES:   state_next = res_load ? ST_IDLE : ST_RES;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring: written on update, read during rebuild
  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      value_ring[ring_write_index] <= sample_hold;
    end
    if (state == ST_RB_RD) begin
      ring_q <= value_ring[rb_idx_next];
    end
  end

  // suffix stack: written during rebuild, top read on update
  always_ff @(posedge clk) begin
    if (state == ST_RB_WR) begin
      suffix_stack[rb_k[AW-1:0]] <= rb_acc_next;
    end
    if (state == ST_UPD) begin
      stack_q <= suffix_stack[AW'(back_count_next - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (feed_acc) begin
      sample_hold <= feed.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind             <= KIND_SUM;
      size_cfg         <= SIZE_RESET;
      slide_cfg        <= SLIDE_RESET;
      front_aggregate  <= agg_identity(KIND_SUM);
      front_count      <= '0;
      back_count       <= '0;
      ring_write_index <= '0;
      items_held       <= '0;
      slide_progress   <= '0;
      rb_k             <= '0;
      rb_idx           <= '0;
      rb_acc           <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg.index == REG_KIND || cfg.index == REG_SIZE) begin
          if (cfg.index == REG_KIND) begin
            kind            <= agg_kind_t'(cfg.data[1:0]);
            front_aggregate <= agg_identity(agg_kind_t'(cfg.data[1:0]));
          end else begin
            size_cfg        <= cfg.data;
            front_aggregate <= agg_identity(kind);
          end
          front_count      <= '0;
          back_count       <= '0;
          ring_write_index <= '0;
          items_held       <= '0;
          slide_progress   <= '0;
        end else if (cfg.index == REG_SLIDE) begin
          slide_cfg <= cfg.data;
        end
      end
      case (state)
        ST_IDLE: begin
          rb_k   <= '0;
          rb_idx <= ring_write_index;
          rb_acc <= agg_identity(kind);
        end
        ST_RB_RD: begin
          rb_idx <= rb_idx_next;
        end
        ST_RB_WR: begin
          rb_acc <= rb_acc_next;
          rb_k   <= rb_k + CW'(1);
          if (rb_k + CW'(1) == front_count) begin
            back_count      <= front_count;
            front_count     <= '0;
            front_aggregate <= agg_identity(kind);
          end
        end
        ST_UPD: begin
          back_count <= back_count_next;
          ring_write_index <= (ring_write_index == AW'(MAX_WINDOW - 1)) ?
                              '0 : ring_write_index + AW'(1);
          front_aggregate <= agg_combine(kind, front_aggregate,
                                         agg_lift(kind, sample_hold));
          front_count <= front_count + CW'(1);
          items_held  <= items_held - (evict ? CW'(1) : CW'(0)) + CW'(1);
          slide_progress <= emit ? '0 : slide_progress + CfgWidth'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.window_value <= agg_combine(kind, back_top, front_aggregate);
      result.window_full  <= full_now;
    end
  end

`include "sliding_window_aggregator_core_defines.svh"

  `SWA_ASSERT_ALWAYS(a_count_split, 32'(items_held) == 32'(front_count) + 32'(back_count), "held count does not match front plus back")
  `SWA_ASSERT_ALWAYS(a_held_bound, items_held <= eff_size || state == ST_IDLE, "window holds more than its size")
  `SWA_ASSERT_IMPL(a_rebuild_empty, state == ST_RB_RD, back_count == '0 && front_count != '0, "rebuild with nonempty back stack")

endmodule

// File: test/sliding_window_aggregator_core_test.sv
module sliding_window_aggregator_core_test;
  import swa_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int SETTLE_CYCLES = 2 * RING_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_ITEMS = 2000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic        full;
  } window_result_t;

  typedef struct {
    bit          is_write;
    logic [1:0]  index;
    logic [10:0] data;
    logic [31:0] sample;
    bit          typed;
    logic [31:0] value;
    logic        full;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  swa_cfg_if    cfg_ch ();
  swa_sample_if feed_ch ();
  swa_result_if res_ch ();

  sliding_window_aggregator_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .feed   (feed_ch),
    .result (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model of the window state
  agg_kind_t   win_kind;
  int unsigned win_size_reg, win_slide_reg;
  logic [31:0] win_ring [RING_DEPTH];
  logic [31:0] win_stack [RING_DEPTH];
  logic [31:0] win_front;
  int unsigned win_front_cnt, win_back_cnt, win_wr, win_held, win_progress;

  window_result_t pending_windows[$];
  int  mismatches = 0;
  int  rx_hold = 0;
  bit  no_gaps = 1'b0;
  int  quiet_cycles = 0;

  function automatic logic [31:0] neutral_of(agg_kind_t k);
    if (k == KIND_MIN) return INT_MAX;
    if (k == KIND_MAX) return INT_MIN;
    return 32'd0;
  endfunction

  function automatic logic [31:0] merge(agg_kind_t k, logic [31:0] a, logic [31:0] b);
    if (k == KIND_MIN) return ($signed(a) < $signed(b)) ? a : b;
    if (k == KIND_MAX) return ($signed(a) > $signed(b)) ? a : b;
    return a + b;
  endfunction

  function automatic logic [31:0] weight(agg_kind_t k, logic [31:0] s);
    return (k == KIND_CNT) ? 32'd1 : s;
  endfunction

  task automatic empty_window();
    win_front = neutral_of(win_kind);
    win_front_cnt = 0;
    win_back_cnt = 0;
    win_wr = 0;
    win_held = 0;
    win_progress = 0;
  endtask

  task automatic apply_write(logic [1:0] idx, logic [10:0] data);
    case (idx)
      REG_KIND: begin
        win_kind = agg_kind_t'(data[1:0]);
        empty_window();
      end
      REG_SIZE: begin
        win_size_reg = 32'(data);
        empty_window();
      end
      REG_SLIDE: win_slide_reg = 32'(data);
      default: ;
    endcase
  endtask

  // Returns 1 when the sample closes a slide.
  function automatic bit window_step(logic [31:0] s, output window_result_t r);
    int unsigned span, step, idx;
    logic [31:0] acc, top;
    span = (win_size_reg == 0) ? 1 : (win_size_reg > RING_DEPTH) ? RING_DEPTH : win_size_reg;
    step = (win_slide_reg == 0) ? 1 : win_slide_reg;
    r = '0;
    if (win_held >= span) begin
      if (win_back_cnt == 0) begin
        // flip front samples into suffix stack, newest at bottom
        acc = neutral_of(win_kind);
        idx = win_wr;
        for (int k = 0; k < win_front_cnt; k++) begin
          idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
          acc = merge(win_kind, weight(win_kind, win_ring[idx]), acc);
          win_stack[k] = acc;
        end
        win_back_cnt = win_front_cnt;
        win_front_cnt = 0;
        win_front = neutral_of(win_kind);
      end
      if (win_back_cnt > 0) begin
        win_back_cnt--;
        win_held--;
      end
    end
    win_ring[win_wr] = s;
    win_wr = (win_wr + 1 >= RING_DEPTH) ? 0 : win_wr + 1;
    win_front = merge(win_kind, win_front_cnt ? win_front : neutral_of(win_kind),
                      weight(win_kind, s));
    win_front_cnt++;
    win_held++;
    win_progress++;
    if (win_progress < step) return 1'b0;
    win_progress = 0;
    top = (win_back_cnt > 0) ? win_stack[win_back_cnt - 1] : neutral_of(win_kind);
    r.value = merge(win_kind, top, win_front_cnt ? win_front : neutral_of(win_kind));
    r.full = (win_held >= span);
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return INT_MAX;
          1: return INT_MIN;
          2: return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_windows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_write(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Caller sits at a falling edge; returns at a falling edge with valid still high.
  task automatic send_sample(logic [31:0] s, bit typed, window_result_t typed_res);
    int gap;
    window_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      feed_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed_ch.valid <= 1'b1;
    feed_ch.sample <= s;
    do @(posedge clk); while (!feed_ch.ready);
    if (window_step(s, r)) pending_windows.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what, window_result_t exp_r, window_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected value %h full %b, got value %h full %b",
               what, exp_r.value, exp_r.full, got.value, got.full);
  endtask

  always @(posedge clk) begin
    window_result_t got, exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.value = res_ch.window_value;
      got.full = res_ch.window_full;
      rx_hold = no_gaps ? 0 : $urandom_range(0, 6);
      if (pending_windows.size() == 0) begin
        report_mismatch("no request pending", '0, got);
      end else begin
        exp_r = pending_windows.pop_front();
        if (exp_r.value !== got.value) report_mismatch("window_value", exp_r, got);
        else if (exp_r.full !== got.full) report_mismatch("window_full", exp_r, got);
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      res_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (feed_ch.valid && feed_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  plan_row_t plan [] = '{
    // reset settings: sum, size 16, slide 4
    '{0, REG_KIND, 11'd0, INT_MAX, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, INT_MIN, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'hFFFF_FFFF, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd1, 1, 32'hFFFF_FFFF, 1'b0},
    '{1, REG_KIND, 11'(KIND_MIN), 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SIZE, 11'd1, 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SLIDE, 11'd1, 32'd0, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd5, 1, 32'd5, 1'b1},
    '{0, REG_KIND, 11'd0, INT_MIN, 1, INT_MIN, 1'b1},
    '{0, REG_KIND, 11'd0, INT_MAX, 1, INT_MAX, 1'b1},
    '{1, REG_KIND, 11'(KIND_MAX), 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SIZE, 11'd3, 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SLIDE, 11'd2, 32'd0, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd0, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'hFFFF_FFF9, 1, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd3, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, INT_MIN, 0, 32'd0, 1'b0},
    // size 0 and slide 0 both act as 1
    '{1, REG_KIND, 11'(KIND_CNT), 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SIZE, 11'd0, 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SLIDE, 11'd0, 32'd0, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd9, 1, 32'd1, 1'b1},
    '{0, REG_KIND, 11'd0, 32'd9, 1, 32'd1, 1'b1},
    // slide shrinks below progress mid-stream; then an out-of-range index
    '{1, REG_KIND, 11'(KIND_SUM), 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SIZE, 11'd4, 32'd0, 0, 32'd0, 1'b0},
    '{1, REG_SLIDE, 11'd3, 32'd0, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd10, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd20, 0, 32'd0, 1'b0},
    '{1, REG_SLIDE, 11'd1, 32'd0, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd30, 1, 32'd60, 1'b0},
    '{1, REG_UNUSED, 11'd5, 32'd0, 0, 32'd0, 1'b0},
    '{0, REG_KIND, 11'd0, 32'd40, 1, 32'd100, 1'b1},
    '{0, REG_KIND, 11'd0, 32'hFFFF_FFFF, 1, 32'd89, 1'b1}
  };

  initial begin
    window_result_t typed_res;
    int sent, count, span, slide;
    bit was_write;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_KIND;
    cfg_ch.data = '0;
    feed_ch.valid = 1'b0;
    feed_ch.sample = '0;
    res_ch.ready = 1'b0;
    win_kind = KIND_SUM;
    win_size_reg = 32'(SIZE_RESET);
    win_slide_reg = 32'(SLIDE_RESET);
    empty_window();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    was_write = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!was_write) begin
          feed_ch.valid <= 1'b0;
          wait_drained();
        end
        write_reg(plan[i].index, plan[i].data);
        was_write = 1'b1;
      end else begin
        typed_res.value = plan[i].value;
        typed_res.full = plan[i].full;
        send_sample(plan[i].sample, plan[i].typed, typed_res);
        was_write = 1'b0;
      end
    end

    sent = 0;
    for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
      feed_ch.valid <= 1'b0;
      wait_drained();
      no_gaps = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        span = RING_DEPTH;
        slide = 32;
        count = 1100;
      end else begin
        case ($urandom_range(0, 9))
          0: span = 0;
          1: span = 2047;
          default: span = $urandom_range(1, 48);
        endcase
        case ($urandom_range(0, 7))
          0: slide = 0;
          1: slide = RING_DEPTH;
          2: slide = 2047;
          default: slide = $urandom_range(1, (span > 1 && span < 64) ? span : 8);
        endcase
        count = (span > 64) ? 60 : $urandom_range(20, 120);
      end
      if (phase < 2 || $urandom_range(0, 9) < 7)
        write_reg(REG_KIND, 11'($urandom_range(0, 3)));
      if (phase < 2 || $urandom_range(0, 9) < 7) write_reg(REG_SIZE, 11'(span));
      write_reg(REG_SLIDE, 11'(slide));
      for (int n = 0; n < count; n++) begin
        if (phase == 0 && n == 50) begin
          feed_ch.valid <= 1'b0;
          @(negedge clk);
          while (pending_windows.size() != 0) @(negedge clk);
        end
        send_sample(pick_sample(), 1'b0, '0);
        sent++;
      end
    end
    feed_ch.valid <= 1'b0;

    while (pending_windows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_windows.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/swa_pkg.sv
src/swa_sample_if.sv
src/swa_result_if.sv
src/swa_cfg_if.sv
src/sliding_window_aggregator_core.sv
test/sliding_window_aggregator_core_test.sv
